// ----- hw/rtl/lbntt_pkg.sv -----
// Shared types and constants of the lazy Barrett NTT engine.
package lbntt_pkg;

  localparam int unsigned MODQ        = 12289;
  localparam int unsigned MU_CONST    = 43687;
  localparam int unsigned MU_SHIFT    = 29;
  localparam int unsigned SCALE_RESET = 12265;
  localparam int unsigned OFFSET_EXP_MAX = 3;  // offset multiple 8 is 2**3

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned VAL_W   = 14;
  localparam int unsigned COEF_W  = 18;
  localparam int unsigned IN_W    = 24;  // index and value, padded to bytes
  localparam int unsigned OUT_W   = 16;  // data, padded to bytes
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned EST_W   = 19;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_FWD_TW = 3'd0,
    FN_WR_INV_TW = 3'd1,
    FN_WR_COEF   = 3'd2,
    FN_RUN_FWD   = 3'd3,
    FN_RUN_INV   = 3'd4,
    FN_READ      = 3'd5
  } func_t;

endpackage

// ----- hw/rtl/lazy_barrett_ntt_engine.sv -----
// Top level of the lazy Barrett NTT engine over Q = 12289.
//
// The engine keeps 2**LOG_SIZE coefficients and two twiddle tables in
// single-port-read RAMs and accepts one transaction at a time on the slave
// stream. Twiddle and coefficient writes give no result. A coefficient read
// returns the low 14 bits of the entry with tuser clear. A forward or inverse
// run returns a zero word with tuser set. Each butterfly reads its two
// operands through the one read port, passes them through the three-stage
// Barrett multiplier and writes both results back through the one write port,
// and the final scaling pass finishes one element before reading the next.
// Forward passes reduce lazily; inverse passes add an offset of Q times 1, 2,
// 4 or 8 and reduce the sums whenever it reaches 8Q. The inverse scale
// register may be written whenever the engine is idle. The result is held in
// an output register, so slave ready is raised again only once the previous
// result has been taken or is being taken.
module lazy_barrett_ntt_engine #(
  parameter int unsigned LOG_SIZE = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  // Slave stream. tdata: index [8:0], value [22:9]. tuser: func [2:0].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lbntt_pkg::IN_W-1:0]       s_tdata,
  input  logic [lbntt_pkg::FUNC_W-1:0]     s_tuser,
  // Master stream. tdata: data [13:0]. tuser: is_done [0].
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lbntt_pkg::OUT_W-1:0]      m_tdata,
  output logic                             m_tuser,
  // Inverse scale register write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbntt_pkg::VAL_W-1:0]      cfg_data
);

  import lbntt_pkg::*;

  localparam int unsigned AW = LOG_SIZE;
  localparam int unsigned BW = LOG_SIZE - 1;
  localparam int unsigned LW = $clog2(LOG_SIZE);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_READ = 14'b00000000000010,
    S_RDU  = 14'b00000000000100,
    S_RDV  = 14'b00000000001000,
    S_MUL1 = 14'b00000000010000,
    S_MUL2 = 14'b00000000100000,
    S_WAIT = 14'b00000001000000,
    S_WR1  = 14'b00000010000000,
    S_WR2  = 14'b00000100000000,
    S_SRD  = 14'b00001000000000,
    S_SMUL = 14'b00010000000000,
    S_SW1  = 14'b00100000000000,
    S_SW2  = 14'b01000000000000,
    S_SWR  = 14'b10000000000000
  } state_t;

  state_t state;

  // Input fields.
  logic [INDEX_W-1:0]          in_index;
  logic [VAL_W-1:0]            in_value;
  logic [INDEX_W+AW-1:0]       in_index_ext;
  logic [AW-1:0]               in_addr;
  logic                        accept;

  assign in_index     = s_tdata[INDEX_W-1:0];
  assign in_value     = s_tdata[INDEX_W+VAL_W-1:INDEX_W];
  assign in_index_ext = {{AW{1'b0}}, in_index};
  assign in_addr      = in_index_ext[AW-1:0];
  assign s_tready     = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept       = s_tvalid && s_tready;
  assign cfg_ready    = 1'b1;

  // Configuration and run control registers.
  logic [VAL_W-1:0] inv_scale;
  logic             fwd;
  logic [LW-1:0]    pass;
  logic [BW-1:0]    bfly;
  logic [AW-1:0]    elem;
  logic [1:0]       kexp;

  // Butterfly operand registers.
  logic [COEF_W-1:0] u_reg;
  logic [VAL_W-1:0]  s_reg;
  logic [COEF_W:0]   sum_reg;
  logic [COEF_W-1:0] r1_reg;

  // Butterfly addressing: j has a zero inserted at bit lt of the butterfly
  // number, its partner sits t = 2**lt further on.
  logic [LW-1:0] lt;
  logic [AW-1:0] b_ext;
  logic [AW-1:0] low_mask;
  logic [AW-1:0] j_addr;
  logic [AW-1:0] t_span;
  logic [AW-1:0] grp;
  logic [AW-1:0] tw_addr;
  logic          last_bfly;
  logic          last_pass;
  logic          last_elem;
  logic          reduce;

  always_comb begin
    lt        = fwd ? LW'(LOG_SIZE - 1) - pass : pass;
    b_ext     = {1'b0, bfly};
    low_mask  = ~({AW{1'b1}} << lt);
    t_span    = AW'(1) << lt;
    grp       = b_ext >> lt;
    j_addr    = ((grp << lt) << 1) | (b_ext & low_mask);
    tw_addr   = (AW'(1) << (LW'(LOG_SIZE - 1) - lt)) + grp;
    last_bfly = (bfly == {BW{1'b1}});
    last_pass = (pass == LW'(LOG_SIZE - 1));
    last_elem = (elem == {AW{1'b1}});
    reduce    = (kexp == 2'(OFFSET_EXP_MAX));
  end

  // Memories.
  logic              coef_we;
  logic [AW-1:0]     coef_waddr;
  logic [COEF_W-1:0] coef_wdata;
  logic [AW-1:0]     coef_raddr;
  logic [COEF_W-1:0] coef_q;
  logic              ftw_we;
  logic              itw_we;
  logic [AW-1:0]     tw_raddr;
  logic [VAL_W-1:0]  ftw_q;
  logic [VAL_W-1:0]  itw_q;

  lbntt_ram #(.WIDTH(COEF_W), .DEPTH(2 ** LOG_SIZE)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  lbntt_ram #(.WIDTH(VAL_W), .DEPTH(2 ** LOG_SIZE)) u_ftw_ram (
    .clk   (clk),
    .we    (ftw_we),
    .waddr (in_addr),
    .wdata (in_value),
    .raddr (tw_raddr),
    .rdata (ftw_q)
  );

  lbntt_ram #(.WIDTH(VAL_W), .DEPTH(2 ** LOG_SIZE)) u_itw_ram (
    .clk   (clk),
    .we    (itw_we),
    .waddr (in_addr),
    .wdata (in_value),
    .raddr (tw_raddr),
    .rdata (itw_q)
  );

  assign ftw_we   = accept && (func_t'(s_tuser) == FN_WR_FWD_TW);
  assign itw_we   = accept && (func_t'(s_tuser) == FN_WR_INV_TW);
  assign tw_raddr = tw_addr;

  // Barrett multiplier: three registered stages ending in the reduced result.
  logic [WORD_W-1:0] mm_a;
  logic [VAL_W-1:0]  mm_b;
  logic [WORD_W-1:0] mm_p;
  logic [WORD_W-1:0] mm_p2;
  logic [EST_W-1:0]  mm_est;
  logic [COEF_W-1:0] mm_res;
  logic [WORD_W+VAL_W-1:0] mm_prod;
  logic [WORD_W+15:0]      mm_qprod;
  logic [EST_W+VAL_W-1:0]  mm_eq;
  logic [WORD_W-1:0]       mm_r;
  logic [WORD_W-1:0]       mm_d;
  logic [WORD_W-1:0]       offset;

  always_comb begin
    offset = WORD_W'(MODQ) << kexp;
    mm_a   = {{(WORD_W-COEF_W){1'b0}}, coef_q};
    mm_b   = VAL_W'(1);
    unique case (state)
      S_MUL1: begin
        mm_b = s_reg;
        if (!fwd) begin
          mm_a = {{(WORD_W-COEF_W){1'b0}}, u_reg}
               - {{(WORD_W-COEF_W){1'b0}}, coef_q} + offset;
        end
      end
      S_MUL2: begin
        mm_a = {{(WORD_W-COEF_W-1){1'b0}}, sum_reg};
      end
      S_SMUL: begin
        mm_b = fwd ? VAL_W'(1) : inv_scale;
      end
      default: begin
      end
    endcase
    mm_prod  = mm_a * mm_b;
    mm_qprod = mm_p * 16'(MU_CONST);
    mm_eq    = mm_est * VAL_W'(MODQ);
    mm_r     = mm_p2 - mm_eq[WORD_W-1:0];
    mm_d     = mm_r - WORD_W'(MODQ);
  end

  always_ff @(posedge clk) begin
    mm_p   <= mm_prod[WORD_W-1:0];
    mm_p2  <= mm_p;
    mm_est <= mm_qprod[MU_SHIFT+EST_W-1:MU_SHIFT];
    mm_res <= mm_d[WORD_W-1] ? mm_r[COEF_W-1:0] : mm_d[COEF_W-1:0];
  end

  // Coefficient RAM ports.
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = in_addr;
    coef_wdata = {{(COEF_W-VAL_W){1'b0}}, in_value};
    coef_raddr = j_addr;
    unique case (state)
      S_IDLE: begin
        coef_raddr = in_addr;
        coef_we    = accept && (func_t'(s_tuser) == FN_WR_COEF);
      end
      S_RDV: begin
        coef_raddr = j_addr | t_span;
      end
      S_WR1: begin
        coef_we    = 1'b1;
        coef_waddr = j_addr | t_span;
        coef_wdata = fwd ? u_reg - mm_res + COEF_W'(MODQ) : mm_res;
      end
      S_WR2: begin
        coef_we    = 1'b1;
        coef_waddr = j_addr;
        coef_wdata = fwd ? u_reg + r1_reg
                         : (reduce ? mm_res : sum_reg[COEF_W-1:0]);
      end
      S_SRD: begin
        coef_raddr = elem;
      end
      S_SWR: begin
        coef_we    = 1'b1;
        coef_waddr = elem;
        coef_wdata = mm_res;
      end
      default: begin
      end
    endcase
  end

  // Operand capture.
  always_ff @(posedge clk) begin
    if (state == S_RDV) begin
      u_reg <= coef_q;
      s_reg <= fwd ? ftw_q : itw_q;
    end
    if (state == S_MUL1) begin
      sum_reg <= {1'b0, u_reg} + {1'b0, coef_q};
    end
    if (state == S_WR1) begin
      r1_reg <= mm_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale <= VAL_W'(SCALE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      inv_scale <= cfg_data;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
      fwd      <= 1'b1;
      pass     <= '0;
      bfly     <= '0;
      elem     <= '0;
      kexp     <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pass <= '0;
            bfly <= '0;
            elem <= '0;
            kexp <= '0;
            case (func_t'(s_tuser))
              FN_RUN_FWD: begin
                fwd   <= 1'b1;
                state <= S_RDU;
              end
              FN_RUN_INV: begin
                fwd   <= 1'b0;
                state <= S_RDU;
              end
              FN_READ: begin
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {{(OUT_W-VAL_W){1'b0}}, coef_q[VAL_W-1:0]};
          m_tuser  <= 1'b0;
          state    <= S_IDLE;
        end
        S_RDU:  state <= S_RDV;
        S_RDV:  state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_WAIT;
        S_WAIT: state <= S_WR1;
        S_WR1:  state <= S_WR2;
        S_WR2: begin
          bfly <= bfly + 1'b1;
          if (last_bfly) begin
            pass <= pass + 1'b1;
            kexp <= reduce ? 2'd0 : kexp + 2'd1;
            state <= last_pass ? S_SRD : S_RDU;
          end else begin
            state <= S_RDU;
          end
        end
        S_SRD:  state <= S_SMUL;
        S_SMUL: state <= S_SW1;
        S_SW1:  state <= S_SW2;
        S_SW2:  state <= S_SWR;
        S_SWR: begin
          elem <= elem + 1'b1;
          if (last_elem) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_SRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_IDLE))
    else $error("slave ready raised outside idle");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDU || state == S_RDV || state == S_SRD) |-> !coef_we)
    else $error("coefficient write collides with operand read");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_READ || state == S_SWR))
    else $error("result raised from an unexpected state");

  a_done_tag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("done result carries data");
`endif

endmodule

// ----- hw/rtl/lbntt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module lbntt_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/lazy_barrett_ntt_engine_tb.sv -----
// Self-checking testbench of the lazy Barrett NTT engine over Q = 12289.
module lazy_barrett_ntt_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbntt_pkg::*;

  localparam int unsigned N = 512;
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam int unsigned QMAX = MODQ - 1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VAL_W-1:0]   value;
  } ntt_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic             is_done;
  } ntt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VAL_W-1:0] cfg_data = '0;

  lazy_barrett_ntt_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Our own copy of the engine's stores and its scale register.
  logic [COEF_W-1:0] coef_store [N];
  logic [VAL_W-1:0]  fwd_twiddle [N];
  logic [VAL_W-1:0]  inv_twiddle [N];
  logic [VAL_W-1:0]  scale_reg = VAL_W'(SCALE_RESET);

  ntt_item_t   pending_items [$];
  ntt_result_t expected_results [$];
  int unsigned mismatches = 0;
  bit          took_item = 1'b0;
  int unsigned hold_requests = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Barrett product: 32-bit wrap, quotient estimate, one conditional subtract.
  function automatic logic [31:0] barrett_mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] p, est, r, d;
    logic [63:0] wide;
    p = a * b;
    wide = 64'(p) * 64'(MU_CONST);
    est = 32'(wide >> MU_SHIFT);
    r = p - est * MODQ;
    d = r - MODQ;
    return d[31] ? d + MODQ : d;
  endfunction

  // Cooley-Tukey passes with lazy sums, then a pass multiplying by one.
  function automatic void ntt_forward();
    int unsigned t, m, i, j, base;
    logic [31:0] s, u, v;
    t = N;
    m = 1;
    while (m < N) begin
      t = t >> 1;
      for (i = 0; i < m; i++) begin
        base = 2 * i * t;
        s = 32'(fwd_twiddle[(m + i) % N]);
        for (j = base; j < base + t; j++) begin
          u = 32'(coef_store[j]);
          v = barrett_mul(32'(coef_store[j + t]), s);
          coef_store[j] = COEF_W'(u + v);
          coef_store[j + t] = COEF_W'(u - v + MODQ);
        end
      end
      m = m << 1;
    end
    for (j = 0; j < N; j++) coef_store[j] = COEF_W'(barrett_mul(32'(coef_store[j]), 1));
  endfunction

  // Gentleman-Sande passes; the offset multiple doubles and the sums are
  // reduced in the pass where it reaches eight, after which it restarts at one.
  function automatic void ntt_inverse();
    int unsigned t, m, h, i, j, base;
    logic [31:0] k, off, s, u, v, sum, dif;
    bit reduce;
    t = 1;
    m = N;
    k = 1;
    while (m > 1) begin
      h = m >> 1;
      off = k * MODQ;
      reduce = (k >= 8);
      base = 0;
      for (i = 0; i < h; i++) begin
        s = 32'(inv_twiddle[(h + i) % N]);
        for (j = base; j < base + t; j++) begin
          u = 32'(coef_store[j]);
          v = 32'(coef_store[j + t]);
          sum = u + v;
          dif = barrett_mul(u - v + off, s);
          coef_store[j] = COEF_W'(reduce ? barrett_mul(sum, 1) : sum);
          coef_store[j + t] = COEF_W'(dif);
        end
        base = base + 2 * t;
      end
      k = reduce ? 32'd1 : k << 1;
      t = t << 1;
      m = m >> 1;
    end
    for (j = 0; j < N; j++)
      coef_store[j] = COEF_W'(barrett_mul(32'(coef_store[j]), 32'(scale_reg)));
  endfunction

  // Updates our copy of the state for one accepted item and queues its result.
  function automatic void apply_item(ntt_item_t it);
    case (it.func)
      FN_WR_FWD_TW: fwd_twiddle[it.index] = it.value;
      FN_WR_INV_TW: inv_twiddle[it.index] = it.value;
      FN_WR_COEF:   coef_store[it.index] = COEF_W'(it.value);
      FN_RUN_FWD: begin
        ntt_forward();
        expected_results.push_back('{data: '0, is_done: 1'b1});
      end
      FN_RUN_INV: begin
        ntt_inverse();
        expected_results.push_back('{data: '0, is_done: 1'b1});
      end
      FN_READ: expected_results.push_back('{data: coef_store[it.index][VAL_W-1:0], is_done: 1'b0});
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Monitor: every transaction on either stream is sampled at the rising edge.
  always @(posedge clk) begin
    ntt_result_t want;
    took_item = s_tvalid && s_tready;
    if (took_item) apply_item('{func: s_tuser, index: s_tdata[INDEX_W-1:0],
                                value: s_tdata[INDEX_W +: VAL_W]});
    if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, data", m_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== OUT_W'(want.data)) report_mismatch("data", m_tdata, want.data);
        if (m_tuser !== want.is_done) report_mismatch("is_done", m_tuser, want.is_done);
      end
    end
  end

  // Gap lengths: mostly none or short, now and then long; sometimes a
  // stretch with no gaps at all.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (steady || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers the queued items one after another at the falling edge.
  int unsigned send_gap = 0;
  bit          send_steady = 1'b0;
  always @(negedge clk) begin
    ntt_item_t it;
    if (!rst && (!s_tvalid || took_item)) begin
      if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {1'b0, it.value, it.index};
        send_gap = pick_gap(send_steady);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  // so that the output register fills and the slave side backs up.
  int unsigned hold_left = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;
  bit          recv_steady = 1'b0;
  always @(negedge clk) begin
    if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = 400;
    end
    if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = pick_gap(recv_steady);
      m_tready <= (stall_left == 0);
    end
  end

  function automatic void queue_item(logic [FUNC_W-1:0] f, int unsigned idx, int unsigned val);
    pending_items.push_back('{func: f, index: INDEX_W'(idx), value: VAL_W'(val)});
  endfunction

  // Waits until every item has gone in and every result has come out, then
  // gives a write or a read time to finish inside the engine.
  task automatic settle();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= VAL_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scale_reg = VAL_W'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_reads(int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_item(FN_READ, $urandom_range(0, N - 1), 0);
  endfunction

  initial begin
    int unsigned r;
    for (int unsigned i = 0; i < N; i++) begin
      coef_store[i] = '0;
      fwd_twiddle[i] = '0;
      inv_twiddle[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every table entry is loaded before anything reads it or a run uses it.
    for (int unsigned i = 0; i < N; i++) begin
      queue_item(FN_WR_FWD_TW, i, $urandom_range(0, QMAX));
      queue_item(FN_WR_INV_TW, i, $urandom_range(0, QMAX));
      queue_item(FN_WR_COEF, i, (i % 7 == 0) ? QMAX : $urandom_range(0, QMAX));
    end

    // Directed part: field extremes, every operation, the unused codes, and
    // a forward run followed by an inverse run at the reset scale.
    queue_item(FN_WR_COEF, 0, 0);
    queue_item(FN_WR_COEF, N - 1, QMAX);
    queue_item(FN_WR_FWD_TW, N - 1, QMAX);
    queue_item(FN_WR_INV_TW, 1, 0);
    queue_item(FN_READ, 0, 0);
    queue_item(FN_READ, N - 1, QMAX);
    queue_item(FN_SPARE_A, N - 1, QMAX);
    queue_item(FN_SPARE_B, 0, 0);
    queue_item(FN_READ, N - 1, 0);
    queue_item(FN_RUN_FWD, 0, 0);
    queue_item(FN_READ, 0, 0);
    queue_item(FN_READ, N - 1, 0);
    queue_item(FN_RUN_INV, N - 1, QMAX);
    queue_item(FN_READ, 0, 0);
    queue_item(FN_READ, 256, 0);
    settle();

    // Scale extremes: zero wipes the store, the largest residue follows.
    write_scale(0);
    queue_item(FN_RUN_INV, 0, 0);
    queue_reads(3);
    for (int unsigned i = 0; i < N; i++) queue_item(FN_WR_COEF, i, $urandom_range(0, QMAX));
    settle();
    write_scale(QMAX);
    queue_item(FN_RUN_INV, 0, 0);
    queue_reads(3);
    settle();
    write_scale($urandom_range(0, QMAX));

    // Random part, with a long receiver hold-off near its start and another midway.
    hold_requests++;
    for (int unsigned n = 0; n < 210; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      queue_item(FN_READ, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 72) queue_item(FN_WR_COEF, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 80) queue_item(FN_WR_FWD_TW, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 88) queue_item(FN_WR_INV_TW, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 91) queue_item(FN_RUN_FWD, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 94) queue_item(FN_RUN_INV, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else if (r < 97) queue_item(FN_SPARE_A, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      else             queue_item(FN_SPARE_B, $urandom_range(0, N - 1), $urandom_range(0, QMAX));
      if (n == 105) begin
        settle();
        write_scale(SCALE_RESET);
        hold_requests++;
      end
    end
    settle();
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: generous against the slowest correct run.
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
